### hdl/stack_with_valid_bits_top_defines.svh
// assertion macros for the stack block
// used by the top level; expects clk and arst_n in scope
`ifndef STACK_WITH_VALID_BITS_TOP_DEFINES_SVH
`define STACK_WITH_VALID_BITS_TOP_DEFINES_SVH

// property must hold at every edge outside reset
`define STK_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// condition must never be seen outside reset
`define STK_ASSERT_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

### hdl/stk_pkg.sv
// shared types and codes for the stack block
// no dependencies
`default_nettype none

package stk_pkg;

	// command codes
	localparam logic [2:0] CMD_READ  = 3'd0;
	localparam logic [2:0] CMD_WRITE = 3'd1;
	localparam logic [2:0] CMD_PUSH  = 3'd2;
	localparam logic [2:0] CMD_POP   = 3'd3;
	localparam logic [2:0] CMD_PEEK  = 3'd4;

	// status codes
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_UNDER = 2'd1;
	localparam logic [1:0] ST_OVER  = 2'd2;

	typedef struct packed {
		logic [2:0]  cmd;
		logic [7:0]  index;
		logic [31:0] value;
	} stk_req_t;

	typedef struct packed {
		logic [31:0] data;
		logic        was_used;
		logic [1:0]  status;
		logic [8:0]  fill;
	} stk_rsp_t;

endpackage

`default_nettype wire

### hdl/stk_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
`default_nettype none

module stk_ram #(
	parameter int WIDTH = 33,
	parameter int DEPTH = 256
) (
	input  wire                       clk,
	input  wire                       we,
	input  wire  [$clog2(DEPTH)-1:0]  waddr,
	input  wire  [WIDTH-1:0]          wdata,
	input  wire                       re,
	input  wire  [$clog2(DEPTH)-1:0]  raddr,
	output logic [WIDTH-1:0]          rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

### hdl/stack_with_valid_bits_top.sv
// stack with random access and a used bit per entry
// depends on stk_pkg, stk_ram and stack_with_valid_bits_top_defines.svh
//
// usage
//   request channel (req_valid / req_ready / req) carries cmd, index, value:
//   read at index, write at index, push, pop and peek at the top
//   response channel (rsp_valid / rsp_ready / rsp) returns one response per
//   request: data, was_used, status and the fill level after the command
//   unused entries read as all-ones poison; pop or peek on an empty stack
//   gives underflow, push on a full stack gives overflow, both with data 0
//   flow: a request's ram read fills the second stage, then its response
//   is registered; no request is taken while one sits in the second
//   stage, for the read then write-back of the single ram (one read, one write port)
//   reset: the top pointer clears at once, then a clearing pass writes
//   every entry of the ram unused, with req_ready low until it is done
//   stall: a finished response waits in the output register; the next
//   request is still taken and its ram read done, then it holds in the
//   second stage until the output register frees up
`default_nettype none

`include "stack_with_valid_bits_top_defines.svh"

module stack_with_valid_bits_top #(
	parameter int DEPTH       = 256,
	parameter int ENTRY_BYTES = 4
) (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              req_valid,
	output logic             req_ready,
	input  stk_pkg::stk_req_t req,
	output logic             rsp_valid,
	input  wire              rsp_ready,
	output stk_pkg::stk_rsp_t rsp
);

	import stk_pkg::*;

	localparam int AW = $clog2(DEPTH);
	localparam int TW = $clog2(DEPTH + 1);
	localparam int EW = ENTRY_BYTES * 8;
	localparam int RW = EW + 1;

	localparam logic [EW-1:0] POISON   = {EW{1'b1}};
	localparam logic [TW-1:0] TOP_FULL = TW'(DEPTH);
	localparam logic [AW-1:0] LAST     = AW'(DEPTH - 1);

	// control state
	logic          clr_q;
	logic [AW-1:0] clr_addr_q;
	logic [TW-1:0] top_q;
	logic          s1_v_q;
	logic          rsp_valid_q;

	// second stage: request waiting for ram data
	logic [2:0]    cmd_s1;
	logic [AW-1:0] addr_s1;
	logic [EW-1:0] val_s1;
	logic [1:0]    status_s1;
	logic          zero_s1;

	stk_rsp_t      rsp_q;

	// index wrapped to the depth, one table entry per index value
	logic [AW-1:0] wrap_idx [256];

	// decode of the incoming request
	logic          accept;
	logic [AW-1:0] addr_d;
	logic [1:0]    status_d;
	logic          zero_d;
	logic [TW-1:0] top_d;
	logic [EW-1:0] val_d;
	logic [EW+31:0] val_ext;

	// ram ports
	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	logic [RW-1:0] ram_wdata;
	logic [RW-1:0] ram_rdata;
	logic          ram_re;

	// second stage results
	logic          s1_fire;
	logic          ent_used;
	logic [EW-1:0] ent_word;
	logic [EW-1:0] ent_read;
	logic [EW-1:0] data_d;
	logic [EW+31:0] data_ext;
	logic          used_d;
	logic          wb_d;
	logic [RW-1:0] wb_word;
	logic [TW+8:0] fill_ext;

	for (genvar g = 0; g < 256; g++) begin : g_wrap
		assign wrap_idx[g] = AW'(g % DEPTH);
	end

	assign accept    = req_valid & req_ready;
	assign req_ready = ~clr_q & ~s1_v_q;

	// value truncated or zero-extended to the entry width
	assign val_ext = {{EW{1'b0}}, req.value};
	assign val_d   = val_ext[EW-1:0];

	always_comb begin
		addr_d   = wrap_idx[req.index];
		status_d = ST_OK;
		zero_d   = 1'b0;
		top_d    = top_q;
		case (req.cmd)
			CMD_READ, CMD_WRITE: begin
				addr_d = wrap_idx[req.index];
			end
			CMD_PUSH: begin
				addr_d = top_q[AW-1:0];
				if (top_q == TOP_FULL) begin
					status_d = ST_OVER;
					zero_d   = 1'b1;
				end else begin
					top_d = top_q + TW'(1);
				end
			end
			CMD_POP, CMD_PEEK: begin
				addr_d = AW'(top_q - TW'(1));
				if (top_q == '0) begin
					status_d = ST_UNDER;
					zero_d   = 1'b1;
				end else if (req.cmd == CMD_POP) begin
					top_d = top_q - TW'(1);
				end
			end
			default: begin
				// unknown command: no operation, zero response
				zero_d = 1'b1;
			end
		endcase
	end

	assign ram_re = accept & ~zero_d;

	// output register frees up this cycle or is empty
	assign s1_fire = s1_v_q & (~rsp_valid_q | rsp_ready);

	// ram word is {used, entry}
	assign ent_used = ram_rdata[EW];
	assign ent_word = ram_rdata[EW-1:0];
	assign ent_read = ent_used ? ent_word : POISON;

	always_comb begin
		data_d  = ent_read;
		used_d  = ent_used;
		wb_d    = 1'b0;
		wb_word = {1'b0, POISON};
		if (zero_s1) begin
			data_d = '0;
			used_d = 1'b0;
		end else begin
			case (cmd_s1)
				CMD_WRITE, CMD_PUSH: begin
					data_d  = val_s1;
					wb_d    = 1'b1;
					wb_word = {1'b1, val_s1};
				end
				CMD_POP: begin
					// poison the popped entry
					wb_d    = 1'b1;
					wb_word = {1'b0, POISON};
				end
				default: begin
					wb_d = 1'b0;
				end
			endcase
		end
	end

	assign data_ext = {32'b0, data_d};
	assign fill_ext = {9'b0, top_q};

	// clearing pass has the write port until it is done
	assign ram_we    = clr_q | (s1_fire & wb_d);
	assign ram_waddr = clr_q ? clr_addr_q : addr_s1;
	assign ram_wdata = clr_q ? {1'b0, POISON} : wb_word;

	stk_ram #(
		.WIDTH (RW),
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (addr_d),
		.rdata (ram_rdata)
	);

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q       <= 1'b1;
			clr_addr_q  <= '0;
			top_q       <= '0;
			s1_v_q      <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (clr_q) begin
				clr_addr_q <= clr_addr_q + AW'(1);
				if (clr_addr_q == LAST) begin
					clr_q <= 1'b0;
				end
			end
			if (accept) begin
				top_q  <= top_d;
				s1_v_q <= 1'b1;
			end else if (s1_fire) begin
				s1_v_q <= 1'b0;
			end
			if (s1_fire) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1    <= req.cmd;
			addr_s1   <= addr_d;
			val_s1    <= val_d;
			status_s1 <= status_d;
			zero_s1   <= zero_d;
		end
		if (s1_fire) begin
			rsp_q.data     <= data_ext[31:0];
			rsp_q.was_used <= used_d;
			rsp_q.status   <= status_s1;
			rsp_q.fill     <= fill_ext[8:0];
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// top pointer stays within the stack
	`STK_ASSERT(a_top_range, top_q <= TOP_FULL, "top pointer beyond depth")
	// nothing is taken while the clearing pass runs or a request is in flight
	`STK_ASSERT_NEVER(a_busy_accept, (clr_q || s1_v_q) && req_ready, "ready while busy")
	// a successful push raises the top by one
	`STK_ASSERT(a_push_top,
		accept && req.cmd == CMD_PUSH && top_q != TOP_FULL |=> top_q == $past(top_q) + TW'(1),
		"push did not raise top")
	// ram is written only by the clearing pass or a request in the second stage
	`STK_ASSERT(a_ram_write_src, ram_we |-> (clr_q || s1_v_q), "stray ram write")

endmodule

`default_nettype wire

### sim/stack_checker.sv
// response checker for the stack block: tracks every accepted request,
// predicts its response and compares it with what comes back
// depends on stk_pkg
`timescale 1ns / 100ps

module stack_checker #(
	parameter int DEPTH = 256
) (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               req_valid,
	input  wire               req_ready,
	input  stk_pkg::stk_req_t req,
	input  wire               rsp_valid,
	input  wire               rsp_ready,
	input  stk_pkg::stk_rsp_t rsp,
	output int                fails,
	output int                pending
);

	import stk_pkg::*;

	localparam logic [31:0] POISON = {4{8'hFF}};

	logic [31:0] word_q [DEPTH];
	bit          live_q [DEPTH];
	logic [8:0]  sp_q;
	stk_rsp_t    owed_rsp_q [$];
	int          fail_tally = 0;

	// one command applied to the shadow stack, returns its response
	function automatic stk_rsp_t stack_step(stk_req_t r);
		stk_rsp_t   o;
		logic [7:0] slot;
		o = '0;
		o.status = ST_OK;
		case (r.cmd)
			CMD_READ: begin
				o.data = live_q[r.index] ? word_q[r.index] : POISON;
				o.was_used = live_q[r.index];
			end
			CMD_WRITE: begin
				o.data = r.value;
				o.was_used = live_q[r.index];
				word_q[r.index] = r.value;
				live_q[r.index] = 1'b1;
			end
			CMD_PUSH: begin
				if (sp_q >= DEPTH) begin
					o.status = ST_OVER;
				end else begin
					slot = sp_q[7:0];
					o.data = r.value;
					o.was_used = live_q[slot];
					word_q[slot] = r.value;
					live_q[slot] = 1'b1;
					sp_q = sp_q + 9'd1;
				end
			end
			CMD_POP: begin
				if (sp_q == 0) begin
					o.status = ST_UNDER;
				end else begin
					sp_q = sp_q - 9'd1;
					slot = sp_q[7:0];
					o.data = live_q[slot] ? word_q[slot] : POISON;
					o.was_used = live_q[slot];
					word_q[slot] = POISON;
					live_q[slot] = 1'b0;
				end
			end
			CMD_PEEK: begin
				if (sp_q == 0) begin
					o.status = ST_UNDER;
				end else begin
					slot = sp_q[7:0] - 8'd1;
					o.data = live_q[slot] ? word_q[slot] : POISON;
					o.was_used = live_q[slot];
				end
			end
			default: ;
		endcase
		o.fill = sp_q;
		return o;
	endfunction

	task automatic flag_field(input string field, input logic [31:0] want_v,
			input logic [31:0] got_v);
		$display("%0t: %s mismatch, expected %h, actual %h", $time, field, want_v, got_v);
		fail_tally++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		stk_rsp_t want;
		if (!arst_n) begin
			for (int i = 0; i < DEPTH; i++) begin
				word_q[i] = '0;
				live_q[i] = 1'b0;
			end
			sp_q = '0;
			owed_rsp_q.delete();
			pending <= 0;
			fails <= fail_tally;
		end else begin
			if (req_valid && req_ready)
				owed_rsp_q.push_back(stack_step(req));
			if (rsp_valid && rsp_ready) begin
				if (owed_rsp_q.size() == 0) begin
					$display("%0t: response with none outstanding, expected nothing, actual %h",
						$time, rsp);
					fail_tally++;
				end else begin
					want = owed_rsp_q.pop_front();
					if (rsp.data !== want.data)
						flag_field("data", want.data, rsp.data);
					if (rsp.was_used !== want.was_used)
						flag_field("was_used", 32'(want.was_used), 32'(rsp.was_used));
					if (rsp.status !== want.status)
						flag_field("status", 32'(want.status), 32'(rsp.status));
					if (rsp.fill !== want.fill)
						flag_field("fill", 32'(want.fill), 32'(rsp.fill));
				end
			end
			pending <= owed_rsp_q.size();
			fails <= fail_tally;
		end
	end

endmodule

### sim/tb_stack_with_valid_bits_top.sv
// testbench top for the stack block: clock, reset, request stimulus,
// response stalls, watchdog and verdict
// depends on stk_pkg, stack_with_valid_bits_top and stack_checker
`timescale 1ns / 100ps

module tb_stack_with_valid_bits_top;
	import stk_pkg::*;

	localparam int DEPTH          = 256;
	localparam int ITEM_TARGET    = 1350;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int TAIL_CYCLES    = 8;

	logic     clk = 1'b0;
	logic     arst_n;
	logic     req_valid;
	logic     req_ready;
	stk_req_t req;
	logic     rsp_valid;
	logic     rsp_ready = 1'b0;
	stk_rsp_t rsp;
	int       fails;
	int       pending;

	// stimulus side bookkeeping: stack height and which entries hold data,
	// so that reads only land on entries that have been written
	int shadow_fill = 0;
	bit ever_written [DEPTH];
	int written_idx [$];
	int n_items = 0;
	int burst_left = 0;

	// receiver stall pattern
	int         stall_mode = 0;
	int         stall_left = 0;
	logic [7:0] stall_mask = 8'h01;

	int quiet_cycles = 0;

	always #10 clk = ~clk;

	stack_with_valid_bits_top #(
		.DEPTH(DEPTH),
		.ENTRY_BYTES(4)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp(rsp)
	);

	stack_checker #(
		.DEPTH(DEPTH)
	) u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp(rsp),
		.fails(fails),
		.pending(pending)
	);

	// data words lean on the extremes now and then
	function automatic logic [31:0] any_word();
		case ($urandom_range(0, 9))
			0: return 32'h0000_0000;
			1: return 32'hFFFF_FFFF;
			default: return $urandom;
		endcase
	endfunction

	// send one request; bursts of random length separated by random gaps,
	// valid stays high across back-to-back requests inside a burst
	task automatic issue(input logic [2:0] cmd, input logic [7:0] idx, input logic [31:0] val);
		stk_req_t   item;
		int         gap;
		logic [7:0] touched;
		bit         stores;
		item.cmd = cmd;
		item.index = idx;
		item.value = val;
		stores = 1'b0;
		touched = idx;
		case (cmd)
			CMD_WRITE: stores = 1'b1;
			CMD_PUSH: begin
				if (shadow_fill < DEPTH) begin
					touched = shadow_fill[7:0];
					stores = 1'b1;
					shadow_fill++;
				end
			end
			CMD_POP: if (shadow_fill > 0) shadow_fill--;
			default: ;
		endcase
		// popped entries count too: they were written before and now hold poison
		if (stores && !ever_written[touched]) begin
			ever_written[touched] = 1'b1;
			written_idx.push_back(int'(touched));
		end
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 12);
			if (gap > 0) begin
				req_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 40);
		end
		burst_left--;
		req <= item;
		req_valid <= 1'b1;
		do @(posedge clk); while (!req_ready);
		n_items++;
	endtask

	// hold off new requests until every response is back
	task automatic drain();
		req_valid <= 1'b0;
		burst_left = 0;
		do @(posedge clk); while (pending != 0);
	endtask

	// one random request; hi below 40 keeps to read and write by index
	task automatic one_random_op(input int hi);
		int r;
		r = $urandom_range(0, hi);
		if (r < 20 || (r < 40 && written_idx.size() == 0))
			issue(CMD_WRITE, 8'($urandom_range(0, DEPTH - 1)), any_word());
		else if (r < 40)
			issue(CMD_READ, 8'(written_idx[$urandom_range(0, written_idx.size() - 1)]),
				$urandom);
		else if (r < 65)
			issue(CMD_PUSH, 8'($urandom), any_word());
		else if (r < 85)
			issue(CMD_POP, 8'($urandom), $urandom);
		else if (r < 95)
			issue(CMD_PEEK, 8'($urandom), $urandom);
		else
			issue(3'($urandom_range(CMD_PEEK + 1, 7)), 8'($urandom), $urandom);
	endtask

	// receiver: ready follows one of a few patterns, each held for a while,
	// including stretches where it never stalls
	always @(posedge clk) begin
		if (stall_left == 0) begin
			stall_mode = $urandom_range(0, 3);
			stall_left = $urandom_range(16, 96);
			stall_mask = 8'($urandom) | 8'h01;
		end
		stall_left--;
		stall_mask = {stall_mask[6:0], stall_mask[7]};
		case (stall_mode)
			0: rsp_ready <= 1'b1;
			1: rsp_ready <= stall_mask[0];
			2: rsp_ready <= ($urandom_range(0, 3) != 0);
			default: rsp_ready <= ($urandom_range(0, 1) == 0);
		endcase
	end

	// watchdog: too long without any request or response moving
	always @(posedge clk) begin
		if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty stack errors first
		issue(CMD_POP, 8'h00, 32'h0000_0000);
		issue(CMD_PEEK, 8'hFF, 32'hFFFF_FFFF);
		// index and value extremes, then read them back
		issue(CMD_WRITE, 8'h00, 32'h0000_0000);
		issue(CMD_WRITE, 8'hFF, 32'hFFFF_FFFF);
		issue(CMD_READ, 8'h00, 32'hFFFF_FFFF);
		issue(CMD_READ, 8'hFF, 32'h0000_0000);
		// rewrite of a used entry
		issue(CMD_WRITE, 8'h00, 32'h1234_5678);
		// write above the top, later overwritten by a push
		issue(CMD_WRITE, 8'h01, 32'hDEAD_BEEF);
		issue(CMD_PUSH, 8'hAA, 32'hA5A5_A5A5);
		issue(CMD_PUSH, 8'h55, 32'h5A5A_5A5A);
		issue(CMD_PEEK, 8'h00, 32'h0000_0000);
		issue(CMD_POP, 8'h00, 32'h0000_0000);
		// popped entry now reads as poison
		issue(CMD_READ, 8'h01, 32'h0000_0000);
		issue(CMD_PEEK, 8'h01, 32'h0000_0000);
		issue(CMD_POP, 8'h00, 32'h0000_0000);
		issue(CMD_READ, 8'h00, 32'h0000_0000);
		issue(CMD_POP, 8'h00, 32'h0000_0000);
		// unknown commands are no-ops
		issue(3'd5, 8'h0F, 32'hFFFF_0000);
		issue(3'd6, 8'hF0, 32'h0000_FFFF);
		issue(3'd7, 8'hFF, 32'hFFFF_FFFF);
		drain();

		// fill to the top, overflow, then empty again and underflow
		while (shadow_fill < DEPTH)
			issue(CMD_PUSH, 8'($urandom), any_word());
		repeat (2) issue(CMD_PUSH, 8'($urandom), any_word());
		issue(CMD_PEEK, 8'($urandom), $urandom);
		while (shadow_fill > 0)
			issue(CMD_POP, 8'($urandom), $urandom);
		repeat (2) issue(CMD_POP, 8'($urandom), $urandom);

		// random phases: mostly stack runs and mixed traffic
		while (n_items < ITEM_TARGET) begin
			case ($urandom_range(0, 11))
				0: begin
					while (shadow_fill < DEPTH)
						issue(CMD_PUSH, 8'($urandom), any_word());
					repeat ($urandom_range(1, 3)) issue(CMD_PUSH, 8'($urandom), any_word());
				end
				1, 2: repeat ($urandom_range(1, 48)) issue(CMD_PUSH, 8'($urandom), any_word());
				3, 4: repeat ($urandom_range(1, 48)) issue(CMD_POP, 8'($urandom), $urandom);
				5: begin
					while (shadow_fill > 0)
						issue(CMD_POP, 8'($urandom), $urandom);
					repeat ($urandom_range(1, 2)) issue(CMD_PEEK, 8'($urandom), $urandom);
				end
				6: repeat ($urandom_range(1, 40)) one_random_op(39);
				7: drain();
				default: repeat ($urandom_range(10, 60)) one_random_op(99);
			endcase
		end

		req_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (fails == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

### files.f
+incdir+hdl
hdl/stk_pkg.sv
hdl/stk_ram.sv
hdl/stack_with_valid_bits_top.sv
sim/stack_checker.sv
sim/tb_stack_with_valid_bits_top.sv
